>>> design/conv3x3_clamp_filter_core_macros.svh
// Assertion macros for the conv3x3 filter checker.
`ifndef CONV3X3_CLAMP_FILTER_CORE_MACROS_SVH
`define CONV3X3_CLAMP_FILTER_CORE_MACROS_SVH

// Clocked property, switched off while reset is held.
`define C3CF_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that is also checked across reset.
`define C3CF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/c3cf_pkg.sv
// Shared types and constants for the 3x3 clamp filter.
package c3cf_pkg;

    localparam int PIX_W     = 8;
    localparam int COEF_W    = 16;
    localparam int TAPS      = 9;
    localparam int POS_W     = 10;
    localparam int DIM_REG_W = 11;
    localparam int CFG_W     = 48;
    localparam int APB_DW    = 64;
    localparam int APB_AW    = 6;
    localparam int MIN_DIM   = 3;
    localparam int PIX_MAX   = 255;
    localparam int MDATA_W   = 32;

    localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 11'd480;

    typedef enum logic [2:0] {
        REG_COEF_TOP    = 3'd0,
        REG_COEF_MIDDLE = 3'd1,
        REG_COEF_BOTTOM = 3'd2,
        REG_WIDTH       = 3'd3,
        REG_HEIGHT      = 3'd4
    } c3cf_reg_t;

    // tap order: top-left first, bottom-right last
    typedef logic [TAPS-1:0][PIX_W-1:0] c3cf_pix_t;

    typedef struct packed {
        logic             last;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } c3cf_meta_t;

endpackage

>>> design/c3cf_front.sv
// Pixel counters, two line stores and the 3x3 window feeding the tap chain.
module c3cf_front import c3cf_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PIX_W-1:0]     s_pixel,
    input  logic [DIM_REG_W-1:0] image_width,
    input  logic [DIM_REG_W-1:0] image_height,
    output logic                 win_valid,
    input  logic                 win_ready,
    output c3cf_pix_t            win_pix,
    output c3cf_meta_t           win_meta
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int DW = CW + 1;
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = RW + 1;

    logic [DW-1:0] eff_w;
    logic [HW-1:0] eff_h;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          f1_valid_reg, f1_valid_next;
    logic          f1_emit_reg;
    logic [PIX_W-1:0] f1_pix_reg;
    logic [CW-1:0] f1_col_reg;
    c3cf_meta_t    f1_meta_reg;

    logic [PIX_W-1:0] rd_prev_reg, rd_prev2_reg;
    logic [PIX_W-1:0] line_prev_reg  [MAX_WIDTH];
    logic [PIX_W-1:0] line_prev2_reg [MAX_WIDTH];
    logic [PIX_W-1:0] win_reg [6];

    logic          accept, f1_move, wrap, emit;
    logic [DW-1:0] c_cur, c_inc;
    logic [HW-1:0] r_pre, r_cur, r_inc;
    logic [31:0]   row_m1, col_m1;
    c3cf_meta_t    meta_cur;

    always_comb begin
        if (image_width < DIM_REG_W'(MIN_DIM)) begin
            eff_w = DW'(MIN_DIM);
        end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
            eff_w = DW'(MAX_WIDTH);
        end else begin
            eff_w = DW'(image_width);
        end
        if (image_height < DIM_REG_W'(MIN_DIM)) begin
            eff_h = HW'(MIN_DIM);
        end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(image_height);
        end
    end

    assign f1_move = f1_valid_reg && (!f1_emit_reg || win_ready);
    assign s_ready = !f1_valid_reg || f1_move;
    assign accept  = s_valid && s_ready;

    // position of the arriving pixel, with wrap if geometry shrank
    always_comb begin
        wrap  = {1'b0, col_reg} >= eff_w;
        c_cur = wrap ? '0 : {1'b0, col_reg};
        r_pre = wrap ? ({1'b0, row_reg} + HW'(1)) : {1'b0, row_reg};
        r_cur = (r_pre >= eff_h) ? '0 : r_pre;
        c_inc = c_cur + DW'(1);
        r_inc = r_cur + HW'(1);
        emit  = (r_cur >= HW'(2)) && (c_cur >= DW'(2));

        row_m1 = 32'(r_cur) - 32'd1;
        col_m1 = 32'(c_cur) - 32'd1;
        meta_cur.row  = row_m1[POS_W-1:0];
        meta_cur.col  = col_m1[POS_W-1:0];
        meta_cur.last = (r_cur == eff_h - HW'(1)) && (c_cur == eff_w - DW'(1));

        col_next      = col_reg;
        row_next      = row_reg;
        f1_valid_next = f1_valid_reg;
        if (f1_move) begin
            f1_valid_next = 1'b0;
        end
        if (accept) begin
            f1_valid_next = 1'b1;
            if (c_inc >= eff_w) begin
                col_next = '0;
                row_next = (r_inc >= eff_h) ? '0 : r_inc[RW-1:0];
            end else begin
                col_next = c_inc[CW-1:0];
                row_next = r_cur[RW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            f1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            f1_valid_reg <= f1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f1_emit_reg <= emit;
            f1_pix_reg  <= s_pixel;
            f1_col_reg  <= c_cur[CW-1:0];
            f1_meta_reg <= meta_cur;
        end
    end

    // line stores: read on accept, written back when the beat leaves stage one
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_prev_reg <= line_prev_reg[c_cur[CW-1:0]];
        end
        if (f1_move) begin
            line_prev_reg[f1_col_reg] <= f1_pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_prev2_reg <= line_prev2_reg[c_cur[CW-1:0]];
        end
        if (f1_move) begin
            line_prev2_reg[f1_col_reg] <= rd_prev_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (f1_move) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= rd_prev2_reg;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= rd_prev_reg;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= f1_pix_reg;
        end
    end

    assign win_valid  = f1_valid_reg && f1_emit_reg;
    assign win_meta   = f1_meta_reg;
    assign win_pix[0] = win_reg[0];
    assign win_pix[1] = win_reg[1];
    assign win_pix[2] = rd_prev2_reg;
    assign win_pix[3] = win_reg[2];
    assign win_pix[4] = win_reg[3];
    assign win_pix[5] = rd_prev_reg;
    assign win_pix[6] = win_reg[4];
    assign win_pix[7] = win_reg[5];
    assign win_pix[8] = f1_pix_reg;

endmodule

>>> design/c3cf_cell.sv
// One tap of the weighted sum: multiply, accumulate, truncate toward zero.
module c3cf_cell import c3cf_pkg::*; #(
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic signed [PIX_W+COEF_W+4-COEF_FRAC_BITS:0] in_acc,
    input  c3cf_pix_t                                   in_pix,
    input  c3cf_meta_t                                  in_meta,
    input  logic [COEF_W-1:0]                           coef,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic signed [PIX_W+COEF_W+4-COEF_FRAC_BITS:0] out_acc,
    output c3cf_pix_t                                   out_pix,
    output c3cf_meta_t                                  out_meta
);

    localparam int ACC_W  = PIX_W + COEF_W + 5 - COEF_FRAC_BITS;
    localparam int NUM_W  = ACC_W + COEF_FRAC_BITS;
    localparam int PROD_W = PIX_W + 1 + COEF_W;
    localparam logic [NUM_W-1:0] BIAS = NUM_W'((1 << COEF_FRAC_BITS) - 1);

    logic                    valid_reg, valid_next;
    logic signed [ACC_W-1:0] acc_reg;
    c3cf_pix_t               pix_reg;
    c3cf_meta_t              meta_reg;

    logic signed [PROD_W-1:0] prod;
    logic signed [NUM_W-1:0]  num, num_adj, quot;
    logic                     load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        prod    = $signed({1'b0, in_pix[0]}) * $signed(coef);
        num     = $signed({in_acc, {COEF_FRAC_BITS{1'b0}}})
                + $signed({{(NUM_W-PROD_W){prod[PROD_W-1]}}, prod});
        num_adj = num + (num[NUM_W-1] ? $signed(BIAS) : $signed(NUM_W'(0)));
        quot    = num_adj >>> COEF_FRAC_BITS;
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            acc_reg  <= quot[ACC_W-1:0];
            pix_reg  <= c3cf_pix_t'(in_pix >> PIX_W);
            meta_reg <= in_meta;
        end
    end

    assign out_valid = valid_reg;
    assign out_acc   = acc_reg;
    assign out_pix   = pix_reg;
    assign out_meta  = meta_reg;

endmodule

>>> design/conv3x3_clamp_filter_core.sv
// Top level of the streaming 3x3 convolution filter with 0..255 clamp.
// Path: the window stage loads on the accepting edge, then nine tap cells and the output register.
// Throughput: one pixel per cycle unless m_tready stalls the output, set by the one-tap-per-cell
// chain; border pixels give no beat.
// Reset clears counters, window, valid flags and config registers; line stores and data registers are not cleared.
module conv3x3_clamp_filter_core import c3cf_pkg::*; #(
    parameter int MAX_WIDTH      = 1024,
    parameter int MAX_HEIGHT     = 1024,
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] pixel_in
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata,    // [7:0] pixel_out, [17:8] center_row,
                                           // [27:18] center_col, [31:28] zero
    output logic               m_tlast,    // frame_last
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int ACC_W = PIX_W + COEF_W + 5 - COEF_FRAC_BITS;

    logic [CFG_W-1:0]     coef_top_reg, coef_mid_reg, coef_bot_reg;
    logic [DIM_REG_W-1:0] width_reg, height_reg;
    logic                 cfg_wr;
    c3cf_reg_t            cfg_sel;
    logic [TAPS-1:0][COEF_W-1:0] coef_taps;

    logic                    chain_valid [TAPS+1];
    logic                    chain_ready [TAPS+1];
    logic signed [ACC_W-1:0] chain_acc   [TAPS+1];
    c3cf_pix_t               chain_pix   [TAPS+1];
    c3cf_meta_t              chain_meta  [TAPS+1];

    logic             m_valid_reg, m_valid_next;
    logic [PIX_W-1:0] m_pix_reg, pix_clamped;
    c3cf_meta_t       m_meta_reg;
    logic signed [ACC_W-1:0] acc_final;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_sel = c3cf_reg_t'(paddr[APB_AW-1:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_top_reg <= '0;
            coef_mid_reg <= '0;
            coef_bot_reg <= '0;
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_COEF_TOP:    coef_top_reg <= pwdata[CFG_W-1:0];
                REG_COEF_MIDDLE: coef_mid_reg <= pwdata[CFG_W-1:0];
                REG_COEF_BOTTOM: coef_bot_reg <= pwdata[CFG_W-1:0];
                REG_WIDTH:       width_reg    <= pwdata[DIM_REG_W-1:0];
                REG_HEIGHT:      height_reg   <= pwdata[DIM_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_COEF_TOP:    prdata = APB_DW'(coef_top_reg);
            REG_COEF_MIDDLE: prdata = APB_DW'(coef_mid_reg);
            REG_COEF_BOTTOM: prdata = APB_DW'(coef_bot_reg);
            REG_WIDTH:       prdata = APB_DW'(width_reg);
            REG_HEIGHT:      prdata = APB_DW'(height_reg);
            default:         prdata = '0;
        endcase
    end

    assign coef_taps = {coef_bot_reg, coef_mid_reg, coef_top_reg};

    c3cf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .s_pixel      (s_tdata),
        .image_width  (width_reg),
        .image_height (height_reg),
        .win_valid    (chain_valid[0]),
        .win_ready    (chain_ready[0]),
        .win_pix      (chain_pix[0]),
        .win_meta     (chain_meta[0])
    );

    assign chain_acc[0] = '0;

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        c3cf_cell #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_acc    (chain_acc[k]),
            .in_pix    (chain_pix[k]),
            .in_meta   (chain_meta[k]),
            .coef      (coef_taps[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_acc   (chain_acc[k+1]),
            .out_pix   (chain_pix[k+1]),
            .out_meta  (chain_meta[k+1])
        );
    end

    // output register with clamp
    assign chain_ready[TAPS] = !m_valid_reg || m_tready;
    assign acc_final         = chain_acc[TAPS];

    always_comb begin
        if (acc_final[ACC_W-1]) begin
            pix_clamped = '0;
        end else if (acc_final > $signed(ACC_W'(PIX_MAX))) begin
            pix_clamped = PIX_W'(PIX_MAX);
        end else begin
            pix_clamped = acc_final[PIX_W-1:0];
        end
        m_valid_next = m_valid_reg;
        if (chain_ready[TAPS]) begin
            m_valid_next = chain_valid[TAPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (chain_ready[TAPS] && chain_valid[TAPS]) begin
            m_pix_reg  <= pix_clamped;
            m_meta_reg <= chain_meta[TAPS];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(MDATA_W - PIX_W - 2*POS_W)'(0), m_meta_reg.col, m_meta_reg.row,
                       m_pix_reg};
    assign m_tlast  = m_meta_reg.last;

endmodule

>>> design/c3cf_checker.sv
// Port-level checker for the 3x3 clamp filter, bound to the top level.
`include "conv3x3_clamp_filter_core_macros.svh"

module c3cf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    `C3CF_ASSERT_RST(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped while stalled")
    `C3CF_ASSERT_RST(a_hold_beat, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast), "stalled result beat changed")
    `C3CF_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result beat shown straight after reset")
    `C3CF_ASSERT_RST(a_interior, aclk, aresetn, m_tvalid |-> m_tdata[17:8] != 10'd0 && m_tdata[27:18] != 10'd0 && m_tdata[31:28] == 4'd0, "border or malformed result beat")

endmodule

bind conv3x3_clamp_filter_core c3cf_checker u_c3cf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
